// ===== src/fdt_pkg.sv =====
package fdt_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int MAX_DEPTH   = 255;
    localparam int DEPTH_BITS  = $clog2(MAX_DEPTH + 1);
    localparam int WORDS_BITS  = OFFSET_BITS - 2;
    localparam int COUNT_BITS  = 16;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [WORDS_BITS-1:0] WORDS_MAX = {WORDS_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [DEPTH_BITS-1:0] DEPTH_LIMIT = DEPTH_BITS'(MAX_DEPTH);

    localparam logic [31:0] TOK_BEGIN   = 32'h0000_0001;
    localparam logic [31:0] TOK_ENDNODE = 32'h0000_0002;
    localparam logic [31:0] TOK_PROP    = 32'h0000_0003;
    localparam logic [31:0] TOK_NOP     = 32'h0000_0004;
    localparam logic [31:0] TOK_END     = 32'h0000_0009;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ITER_MODE    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_OFFSET = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STRUCT_END   = 2'd2;

    typedef enum logic [2:0] {
        PH_TOKEN   = 3'd0,
        PH_NAME    = 3'd1,
        PH_LEN     = 3'd2,
        PH_NAMEOFF = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_WALK = 2'd1,
        ST_DONE = 2'd2
    } stage_t;

    typedef enum logic [2:0] {
        EV_FOUND     = 3'd0,
        EV_NOMORE    = 3'd1,
        EV_BADSTRUCT = 3'd2,
        EV_UNKNOWN   = 3'd3,
        EV_BADSTART  = 3'd4
    } event_t;

    typedef struct packed {
        logic   valid;
        event_t code;
    } evt_t;

    function automatic logic has_nul(input logic [31:0] w);
        return (w[31:24] == 8'h00) || (w[23:16] == 8'h00) ||
               (w[15:8] == 8'h00) || (w[7:0] == 8'h00);
    endfunction

endpackage

// ===== src/fdt_structure_iterator.sv =====
// Walks a flattened devicetree structure block one 32-bit big-endian word per
// transaction, starting at the target node's BEGIN_NODE token (s_first = 1).
// With iter_mode 0 it reports each property of the target node, with
// iter_mode 1 each direct child node, and it closes the walk with a
// "no more entries" or an error result; words that arrive after the walk has
// ended are consumed silently. The whole token and phase update sits between
// the input handshake and the result register, so a word can be accepted in
// every cycle while the result register is empty or its result is taken in
// the same cycle. A result that waits on m_ready holds off the input until
// it is taken.
// Configuration may be written only while no result is pending.
module fdt_structure_iterator
    import fdt_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [OFFSET_BITS-1:0]  cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [31:0]             s_word,
    input  logic                    s_first,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [2:0]              m_event_res,
    output logic [OFFSET_BITS-1:0]  m_found_offset,
    output logic [COUNT_BITS-1:0]   m_found_index
);

    logic                   iter_mode_reg;
    logic [OFFSET_BITS-1:0] start_offset_reg;
    logic [OFFSET_BITS-1:0] struct_end_reg;

    logic [OFFSET_BITS-1:0] pos_reg, pos_next, pos_eff;
    phase_t                 phase_reg, phase_next, phase_eff;
    logic [WORDS_BITS-1:0]  pwl_reg, pwl_next, pwl_eff;
    logic [DEPTH_BITS-1:0]  depth_reg, depth_next, depth_eff;
    stage_t                 stage_reg, stage_next, stage_eff;
    logic [COUNT_BITS-1:0]  cnt_reg, cnt_next, cnt_eff;

    logic                   m_valid_reg;
    event_t                 event_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [COUNT_BITS-1:0]  index_reg;

    logic                   in_fire;
    logic                   bad_start;
    logic                   active;
    logic                   overrun;
    logic [32:0]            len_words;
    logic [WORDS_BITS-1:0]  pwl_dec;
    evt_t                   evt;

    assign in_fire = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iter_mode_reg    <= 1'b0;
            start_offset_reg <= '0;
            struct_end_reg   <= POS_MAX;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ITER_MODE:    iter_mode_reg    <= cfg_data[0];
                CFG_START_OFFSET: start_offset_reg <= cfg_data;
                CFG_STRUCT_END:   struct_end_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // A first word restarts the walk before it is decoded.
    always_comb begin
        if (s_first) begin
            pos_eff   = start_offset_reg;
            phase_eff = PH_TOKEN;
            pwl_eff   = '0;
            depth_eff = '0;
            stage_eff = ST_WALK;
            cnt_eff   = '0;
        end else begin
            pos_eff   = pos_reg;
            phase_eff = phase_reg;
            pwl_eff   = pwl_reg;
            depth_eff = depth_reg;
            stage_eff = stage_reg;
            cnt_eff   = cnt_reg;
        end
    end

    assign bad_start = s_first && (s_word != TOK_BEGIN);
    assign active    = (stage_eff == ST_WALK) && !bad_start;
    assign overrun   = pos_eff >= struct_end_reg;
    assign len_words = ({1'b0, s_word} + 33'd3) >> 2;
    assign pwl_dec   = (pwl_eff != '0) ? pwl_eff - 1'b1 : pwl_eff;

    always_comb begin
        evt.valid = 1'b0;
        evt.code  = EV_FOUND;
        if (bad_start) begin
            evt.valid = 1'b1;
            evt.code  = EV_BADSTART;
        end else if (active && phase_eff == PH_TOKEN) begin
            if (overrun) begin
                evt.valid = 1'b1;
                evt.code  = EV_BADSTRUCT;
            end else begin
                case (s_word)
                    TOK_BEGIN: begin
                        if (depth_eff == DEPTH_BITS'(1)) begin
                            evt.valid = 1'b1;
                            evt.code  = iter_mode_reg ? EV_FOUND : EV_NOMORE;
                        end else if (depth_eff >= DEPTH_LIMIT) begin
                            evt.valid = 1'b1;
                            evt.code  = EV_BADSTRUCT;
                        end
                    end
                    TOK_PROP: begin
                        if (depth_eff == DEPTH_BITS'(1)) begin
                            if (!iter_mode_reg) begin
                                evt.valid = 1'b1;
                                evt.code  = EV_FOUND;
                            end else if (cnt_eff != '0) begin
                                evt.valid = 1'b1;
                                evt.code  = EV_BADSTRUCT;
                            end
                        end
                    end
                    TOK_ENDNODE: begin
                        if (depth_eff <= DEPTH_BITS'(1)) begin
                            evt.valid = 1'b1;
                            evt.code  = EV_NOMORE;
                        end
                    end
                    TOK_NOP: ;
                    TOK_END: begin
                        evt.valid = 1'b1;
                        evt.code  = EV_BADSTRUCT;
                    end
                    default: begin
                        evt.valid = 1'b1;
                        evt.code  = EV_UNKNOWN;
                    end
                endcase
            end
        end
    end

    always_comb begin
        pos_next   = pos_eff;
        phase_next = phase_eff;
        pwl_next   = pwl_eff;
        depth_next = depth_eff;
        stage_next = stage_eff;
        cnt_next   = cnt_eff;
        if (active) begin
            case (phase_eff)
                PH_NAME: begin
                    if (has_nul(s_word)) begin
                        phase_next = PH_TOKEN;
                    end
                end
                PH_LEN: begin
                    pwl_next   = (len_words > 33'(WORDS_MAX)) ? WORDS_MAX
                                                               : len_words[WORDS_BITS-1:0];
                    phase_next = PH_NAMEOFF;
                end
                PH_NAMEOFF: begin
                    phase_next = (pwl_eff == '0) ? PH_TOKEN : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    pwl_next = pwl_dec;
                    if (pwl_dec == '0) begin
                        phase_next = PH_TOKEN;
                    end
                end
                default: begin
                    phase_next = PH_TOKEN;
                    if (!overrun) begin
                        case (s_word)
                            TOK_BEGIN: begin
                                phase_next = PH_NAME;
                                if (depth_eff == DEPTH_BITS'(1)) begin
                                    if (iter_mode_reg) begin
                                        depth_next = depth_eff + 1'b1;
                                    end
                                end else if (depth_eff < DEPTH_LIMIT) begin
                                    depth_next = depth_eff + 1'b1;
                                end
                            end
                            TOK_PROP: phase_next = PH_LEN;
                            TOK_ENDNODE: begin
                                if (depth_eff > DEPTH_BITS'(1)) begin
                                    depth_next = depth_eff - 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            endcase
            pos_next = (pos_eff > POS_MAX - OFFSET_BITS'(4)) ? POS_MAX
                                                             : pos_eff + OFFSET_BITS'(4);
        end
        if (evt.valid) begin
            if (evt.code == EV_FOUND) begin
                if (cnt_eff != COUNT_MAX) begin
                    cnt_next = cnt_eff + 1'b1;
                end
            end else begin
                stage_next = ST_DONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            phase_reg <= PH_TOKEN;
            pwl_reg   <= '0;
            depth_reg <= '0;
            stage_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else if (in_fire) begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            pwl_reg   <= pwl_next;
            depth_reg <= depth_next;
            stage_reg <= stage_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire && evt.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && evt.valid) begin
            event_reg  <= evt.code;
            offset_reg <= (evt.code == EV_FOUND) ? pos_eff : '0;
            index_reg  <= cnt_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_event_res    = event_reg;
    assign m_found_offset = offset_reg;
    assign m_found_index  = index_reg;

    a_bad_start: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_first && (s_word != TOK_BEGIN) |=>
            m_valid && (m_event_res == EV_BADSTART) && (stage_reg == ST_DONE))
        else $error("bad start did not end the walk with its result");

    a_depth_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_LIMIT)
        else $error("nesting depth beyond its limit");

    a_payload_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD) |-> (pwl_reg != '0))
        else $error("payload phase with no payload words left");

    a_offset_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res != EV_FOUND) |-> (m_found_offset == '0))
        else $error("offset reported on a result that is not a find");

endmodule
